[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with an explicit clock and active-low reset.
`define ASSERT_AT(label, clock, rst_n, prop, msg) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) (prop)) \
		else $error(msg);

// Clocked property on the usual clk / arst_n pair.
`define ASSERT_CLK(label, prop, msg) \
	`ASSERT_AT(label, clk, arst_n, prop, msg)

`endif

[design/tsd_pkg.sv]
// ----------------------------------------------------------------------------
// tsd_pkg
// Shared types and constants of the touch sense hysteresis/debounce block.
// ----------------------------------------------------------------------------
`default_nettype none

package tsd_pkg;

	localparam int CFG_DATA_W  = 12;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_VALUE_W = 10;  // width of min_value / max_value
	localparam int MASK_W      = 12;
	localparam int CNT_W       = 9;
	localparam int WEIGHT_W    = 9;
	localparam int WEIGHT_SHIFT = 8;
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_ACTIVE_MASK   = 3'd0,
		CFG_WEIGHT        = 3'd1,
		CFG_MIN_VALUE     = 3'd2,
		CFG_MAX_VALUE     = 3'd3,
		CFG_TOUCH_MARGIN  = 3'd4,
		CFG_REL_MARGIN    = 3'd5,
		CFG_TOUCH_COUNT   = 3'd6,
		CFG_REL_COUNT     = 3'd7
	} cfg_reg_t;

	localparam logic [11:0] RST_ACTIVE_MASK  = 12'd4095;
	localparam logic [8:0]  RST_WEIGHT       = 9'd26;
	localparam logic [9:0]  RST_MIN_VALUE    = 10'd600;
	localparam logic [9:0]  RST_MAX_VALUE    = 10'd710;
	localparam logic [7:0]  RST_TOUCH_MARGIN = 8'd30;
	localparam logic [7:0]  RST_REL_MARGIN   = 8'd20;
	localparam logic [7:0]  RST_TOUCH_COUNT  = 8'd15;
	localparam logic [7:0]  RST_REL_COUNT    = 8'd15;

	typedef struct packed {
		logic [11:0] active_port_mask;
		logic [8:0]  smoothing_weight;
		logic [9:0]  min_value;
		logic [9:0]  max_value;
		logic [7:0]  touch_margin;
		logic [7:0]  release_margin;
		logic [7:0]  touch_count;
		logic [7:0]  release_count;
	} cfg_t;

	typedef struct packed {
		logic [3:0] port;
		logic [9:0] raw_sample;
	} sample_t;

	typedef struct packed {
		logic [3:0]  port_echo;
		logic        touched;
		logic        changed;
		logic [11:0] touch_mask;
		logic [9:0]  smoothed_value;
	} result_t;

endpackage

`default_nettype wire

[design/touch_sense_hysteresis_debounce_top.sv]
// An accepted request waits in the input stage until the result register frees up.
// Throughput: one request per cycle when not stalled, set by the read-modify-write
// of the port's state registers between the input stage and the result register.
// Reset: asynchronous, active low; settings return to defaults, every port is
// released and unprimed, and no result is pending.
// ----------------------------------------------------------------------------
// touch_sense_hysteresis_debounce_top
// Per-electrode capacitive touch detector with smoothing, hysteresis and
// debounce, one sample per request, one result per request.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module touch_sense_hysteresis_debounce_top import tsd_pkg::*; #(
	parameter int PORTS         = 12,
	parameter int SAMPLE_BITS   = 10,
	parameter int FRACTION_BITS = 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// sample channel
	input  wire logic                   sample_valid,
	output logic                        sample_stall,
	input  wire sample_t                sample,
	// result channel
	output logic                        result_valid,
	input  wire logic                   result_stall,
	output result_t                     result,
	// configuration write port
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int VAL_W = CFG_VALUE_W + FRACTION_BITS;
	localparam int TH_W  = VAL_W + 2;
	localparam int IDX_W = (PORTS > 1) ? $clog2(PORTS) : 1;

	cfg_t cfg;

	tsd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Input stage: holds the accepted request while its port state is updated.
	sample_t sample_s1;
	logic    valid_s1;
	logic    advance;
	logic    take;

	// Per-port state, one register set per electrode.
	logic [VAL_W-1:0] value_q  [PORTS];
	logic [TH_W-1:0]  thresh_q [PORTS];
	logic [CNT_W-1:0] count_q  [PORTS];
	logic [PORTS-1:0] touch_q;
	logic [PORTS-1:0] primed_q;

	result_t result_q;
	logic    result_valid_q;

	// The result register frees up when empty or when its result leaves.
	assign advance      = valid_s1 & (~result_valid_q | ~result_stall);
	assign sample_stall = valid_s1 & ~advance;
	assign take         = sample_valid & ~sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sample_s1 <= sample;
		end
	end

	// Port decode: ports past PORTS or past the mask width are never active.
	logic [15:0]      mask_ext;
	logic             in_range;
	logic             active;
	logic [IDX_W-1:0] idx;

	assign mask_ext = 16'(cfg.active_port_mask);
	assign in_range = {1'b0, sample_s1.port} < 5'(PORTS);
	assign active   = in_range & mask_ext[sample_s1.port];
	assign idx      = sample_s1.port[IDX_W-1:0];

	logic [VAL_W-1:0] upd_value;
	logic [TH_W-1:0]  upd_thresh;
	logic [CNT_W-1:0] upd_count;
	logic             upd_touched;
	logic             upd_changed;

	tsd_update #(
		.SAMPLE_BITS   (SAMPLE_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_update (
		.cfg       (cfg),
		.raw       (sample_s1.raw_sample),
		.value_i   (value_q[idx]),
		.thresh_i  (thresh_q[idx]),
		.count_i   (count_q[idx]),
		.touched_i (touch_q[idx]),
		.primed_i  (primed_q[idx]),
		.value_o   (upd_value),
		.thresh_o  (upd_thresh),
		.count_o   (upd_count),
		.touched_o (upd_touched),
		.changed_o (upd_changed)
	);

	logic             write_state;
	logic [PORTS-1:0] touch_next;
	logic [15:0]      touch_ext;

	assign write_state = advance & active;

	// Touch bits as they stand after this request, for the mask output.
	always_comb begin
		touch_next = touch_q;
		if (active) begin
			touch_next[idx] = upd_touched;
		end
	end
	assign touch_ext = 16'(touch_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PORTS; i++) begin
				value_q[i]  <= '0;
				thresh_q[i] <= '0;
				count_q[i]  <= '0;
			end
			touch_q  <= '0;
			primed_q <= '0;
		end else if (write_state) begin
			value_q[idx]  <= upd_value;
			thresh_q[idx] <= upd_thresh;
			count_q[idx]  <= upd_count;
			touch_q[idx]  <= upd_touched;
			primed_q[idx] <= 1'b1;
		end
	end

	// Result register: inactive or out-of-range ports report zero touched, changed and value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (~result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.port_echo      <= sample_s1.port;
			result_q.touched        <= active & upd_touched;
			result_q.changed        <= active & upd_changed;
			result_q.touch_mask     <= touch_ext[MASK_W-1:0] & cfg.active_port_mask;
			result_q.smoothed_value <= active ? upd_value[VAL_W-1:FRACTION_BITS] : '0;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Assertions
	`ASSERT_CLK(a_stall_only_when_held, sample_stall |-> valid_s1,
		"input stalled with an empty input stage")
	`ASSERT_CLK(a_primed_never_clears, ($past(primed_q) & ~primed_q) == '0,
		"a primed port lost its primed bit")
	`ASSERT_CLK(a_change_flips_bit, (advance && active && upd_changed) |=>
		(touch_q != $past(touch_q)), "reported touch change did not flip state")

endmodule

`default_nettype wire

[design/tsd_cfg.sv]
// ----------------------------------------------------------------------------
// tsd_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module tsd_cfg import tsd_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
	output cfg_t                        cfg
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.active_port_mask <= RST_ACTIVE_MASK;
			cfg.smoothing_weight <= RST_WEIGHT;
			cfg.min_value        <= RST_MIN_VALUE;
			cfg.max_value        <= RST_MAX_VALUE;
			cfg.touch_margin     <= RST_TOUCH_MARGIN;
			cfg.release_margin   <= RST_REL_MARGIN;
			cfg.touch_count      <= RST_TOUCH_COUNT;
			cfg.release_count    <= RST_REL_COUNT;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ACTIVE_MASK:  cfg.active_port_mask <= cfg_wdata[11:0];
				CFG_WEIGHT:       cfg.smoothing_weight <= cfg_wdata[8:0];
				CFG_MIN_VALUE:    cfg.min_value        <= cfg_wdata[9:0];
				CFG_MAX_VALUE:    cfg.max_value        <= cfg_wdata[9:0];
				CFG_TOUCH_MARGIN: cfg.touch_margin     <= cfg_wdata[7:0];
				CFG_REL_MARGIN:   cfg.release_margin   <= cfg_wdata[7:0];
				CFG_TOUCH_COUNT:  cfg.touch_count      <= cfg_wdata[7:0];
				CFG_REL_COUNT:    cfg.release_count    <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

[design/tsd_update.sv]
// ----------------------------------------------------------------------------
// tsd_update
// Per-port next-state logic: smoothing, clamp, hysteresis compare, debounce.
// ----------------------------------------------------------------------------
`default_nettype none

module tsd_update import tsd_pkg::*; #(
	parameter int SAMPLE_BITS   = 10,
	parameter int FRACTION_BITS = 8,
	localparam int VAL_W = CFG_VALUE_W + FRACTION_BITS,
	localparam int TH_W  = VAL_W + 2
) (
	input  wire cfg_t               cfg,
	input  wire logic [9:0]         raw,
	input  wire logic [VAL_W-1:0]   value_i,
	input  wire logic [TH_W-1:0]    thresh_i,
	input  wire logic [CNT_W-1:0]   count_i,
	input  wire logic               touched_i,
	input  wire logic               primed_i,
	output logic [VAL_W-1:0]        value_o,
	output logic [TH_W-1:0]         thresh_o,
	output logic [CNT_W-1:0]        count_o,
	output logic                    touched_o,
	output logic                    changed_o
);

	localparam int RW = (SAMPLE_BITS < 10) ? SAMPLE_BITS : 10;
	localparam int DW = VAL_W + 1;
	localparam int PW = DW + WEIGHT_W + 1;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	logic [VAL_W-1:0]        s_val;
	logic [WEIGHT_W-1:0]     w_sat;
	logic signed [DW-1:0]    diff;
	logic signed [WEIGHT_W:0] w_s;
	logic signed [PW-1:0]    prod;
	logic signed [PW-1:0]    sum;
	logic [VAL_W-1:0]        cand;
	logic [VAL_W-1:0]        lo;
	logic [VAL_W-1:0]        hi;
	logic [VAL_W-1:0]        v;
	logic signed [TH_W-1:0]  v_s;
	logic signed [TH_W-1:0]  thr_touch;
	logic signed [TH_W-1:0]  thr_rel;
	logic signed [TH_W-1:0]  th_s;
	logic                    hit;
	logic [CNT_W-1:0]        cnt_next;
	logic [7:0]              limit;
	logic                    flip;

	always_comb begin
		s_val = VAL_W'({raw[RW-1:0], {FRACTION_BITS{1'b0}}});
		w_sat = (cfg.smoothing_weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg.smoothing_weight;

		// old + w*(s-old)/256, floor taken by the arithmetic shift
		diff = $signed({1'b0, s_val}) - $signed({1'b0, value_i});
		w_s  = $signed({1'b0, w_sat});
		prod = w_s * diff;
		sum  = (prod >>> WEIGHT_SHIFT) + $signed({{(PW-VAL_W){1'b0}}, value_i});

		cand = primed_i ? sum[VAL_W-1:0] : s_val;
		lo   = {cfg.min_value, {FRACTION_BITS{1'b0}}};
		hi   = {cfg.max_value, {FRACTION_BITS{1'b0}}};
		if (cand < lo) begin
			v = lo;
		end else if (cand > hi) begin
			v = hi;
		end else begin
			v = cand;
		end

		v_s       = $signed({2'b00, v});
		th_s      = $signed(thresh_i);
		thr_touch = v_s - $signed(TH_W'({cfg.touch_margin, {FRACTION_BITS{1'b0}}}));
		thr_rel   = v_s + $signed(TH_W'({cfg.release_margin, {FRACTION_BITS{1'b0}}}));

		hit = touched_i ? (v_s > th_s) : (v_s < th_s);
		if (!hit) begin
			cnt_next = '0;
		end else if (count_i == CNT_MAX) begin
			cnt_next = count_i;
		end else begin
			cnt_next = count_i + 1'b1;
		end
		limit = touched_i ? cfg.release_count : cfg.touch_count;
		flip  = cnt_next > CNT_W'(limit);

		value_o   = v;
		touched_o = touched_i;
		changed_o = 1'b0;
		if (!primed_i) begin
			thresh_o = thr_touch;
			count_o  = '0;
		end else if (flip) begin
			thresh_o  = touched_i ? thr_touch : thr_rel;
			count_o   = '0;
			touched_o = ~touched_i;
			changed_o = 1'b1;
		end else begin
			thresh_o = thresh_i;
			count_o  = cnt_next;
		end
	end

endmodule

`default_nettype wire
